FILE: rtl/core/mka_pkg.sv
// mka_pkg: shared types, codes and reset constants for the mac keyed id allocator
// depends on nothing; imported by mac_keyed_id_allocator and its testbench
`timescale 1ns / 1ps
`default_nettype none

package mka_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 32;
  localparam int unsigned RESULT_LIMIT    = 32;
  localparam int unsigned MATCH_W         = $clog2(RESULT_LIMIT + 1);

  localparam int unsigned MAC_W  = 48;
  localparam int unsigned TYPE_W = 16;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned CFG_W  = 16;

  localparam logic [ID_W-1:0]   FIRST_ID_RST      = 16'd100;
  localparam logic [TYPE_W-1:0] OPERATOR_TYPE_RST = 16'd20001;
  localparam logic [TYPE_W-1:0] VEHICLE_TYPE_RST  = 16'd10001;

  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_QUERY   = 1'b1;

  typedef enum logic [2:0] {
    STAT_NEW   = 3'd0,
    STAT_KNOWN = 3'd1,
    STAT_FULL  = 3'd2,
    STAT_ENTRY = 3'd3,
    STAT_EMPTY = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    QK_ALL      = 2'd0,
    QK_OPERATOR = 2'd1,
    QK_VEHICLE  = 2'd2,
    QK_MAC      = 2'd3
  } qkind_e;

  typedef enum logic [1:0] {
    CFG_FIRST_ID = 2'd0,
    CFG_OPERATOR = 2'd1,
    CFG_VEHICLE  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DONE
  } fsm_e;

  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [TYPE_W-1:0] node_type;
    logic [ID_W-1:0]   id;
  } entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/mac_keyed_id_allocator.sv
// mac keyed id allocator: node table scanned one entry per cycle by a small sequencer,
// except while a second match waits for the output to drain; a request that hits
// stops its scan early; one transaction in work at a time, so the transaction rate is
// set by the single table read port and its compare; the scan is held only by a
// stalled output
// reset clears the entry count, the sequencer and the config registers; the table
// itself is not cleared and only entries below the count are ever read
`timescale 1ns / 1ps
`default_nettype none

module mac_keyed_id_allocator #(
  parameter int unsigned TABLE_DEPTH = mka_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        command_i,
  input  wire logic [mka_pkg::MAC_W-1:0]   mac_i,
  input  wire logic [mka_pkg::TYPE_W-1:0]  node_type_i,
  input  wire logic [1:0]                  query_kind_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [2:0]                       status_o,
  output logic [mka_pkg::ID_W-1:0]         subsystem_id_o,
  output logic [mka_pkg::TYPE_W-1:0]       entry_type_o,
  output logic [mka_pkg::MAC_W-1:0]        entry_mac_o,
  output logic                             last_item_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [1:0]                  cfg_idx_i,
  input  wire logic [mka_pkg::CFG_W-1:0]   cfg_data_i
);
  import mka_pkg::*;

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  // table memory, one read and one write port
  entry_t mem_q [TABLE_DEPTH];
  entry_t rdata_q;
  logic   rd_en;
  logic   wr_en;
  entry_t wdata;

  fsm_e state_q, state_d;
  logic [CntW-1:0]    entry_count_q, entry_count_d;
  logic [ID_W-1:0]    next_id_q, next_id_d;
  logic [TYPE_W-1:0]  op_type_q, op_type_d;
  logic [TYPE_W-1:0]  veh_type_q, veh_type_d;

  // latched transaction
  logic               cmd_q, cmd_d;
  logic [MAC_W-1:0]   mac_q, mac_d;
  logic [TYPE_W-1:0]  type_q, type_d;
  logic [1:0]         kind_q, kind_d;

  // scan control
  logic [CntW-1:0]    rd_idx_q, rd_idx_d;
  logic               cv_q, cv_d;
  logic [MATCH_W-1:0] match_cnt_q, match_cnt_d;
  logic               held_v_q, held_v_d;
  entry_t             held_q, held_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [2:0]         status_q, status_d;
  logic [ID_W-1:0]    out_id_q, out_id_d;
  logic [TYPE_W-1:0]  out_type_q, out_type_d;
  logic [MAC_W-1:0]   out_mac_q, out_mac_d;
  logic               out_last_q, out_last_d;

  logic               hit;
  logic               cmp_hit;
  logic               out_free;
  logic               stall;
  logic               stop;
  logic               issue;
  logic [MATCH_W-1:0] match_next;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[entry_count_q[IdxW-1:0]] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_idx_q[IdxW-1:0]];
    end
  end

  always_comb begin
    case (kind_q)
      QK_ALL:      hit = 1'b1;
      QK_OPERATOR: hit = (rdata_q.node_type == op_type_q);
      QK_VEHICLE:  hit = (rdata_q.node_type == veh_type_q);
      default:     hit = (rdata_q.mac == mac_q);
    endcase
    if (cmd_q == CMD_REQUEST) begin
      hit = (rdata_q.mac == mac_q);
    end
  end

  assign cmp_hit    = cv_q && hit;
  assign out_free   = !out_valid_q || out_ready_i;
  // a second match has to push the held one out first
  assign stall      = cmp_hit && held_v_q && !out_free;
  assign match_next = match_cnt_q + MATCH_W'(cmp_hit);
  assign stop       = (cmd_q == CMD_REQUEST) ? (held_v_q || cmp_hit)
                                             : (match_next == MATCH_W'(RESULT_LIMIT));
  assign issue      = !stall && (rd_idx_q < entry_count_q) && !stop;

  always_comb begin
    state_d       = state_q;
    entry_count_d = entry_count_q;
    next_id_d     = next_id_q;
    op_type_d     = op_type_q;
    veh_type_d    = veh_type_q;
    cmd_d         = cmd_q;
    mac_d         = mac_q;
    type_d        = type_q;
    kind_d        = kind_q;
    rd_idx_d      = rd_idx_q;
    cv_d          = cv_q;
    match_cnt_d   = match_cnt_q;
    held_v_d      = held_v_q;
    held_d        = held_q;
    out_valid_d   = out_valid_q;
    status_d      = status_q;
    out_id_d      = out_id_q;
    out_type_d    = out_type_q;
    out_mac_d     = out_mac_q;
    out_last_d    = out_last_q;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wdata         = '{mac: mac_q, node_type: type_q, id: next_id_q};
    in_ready_o    = (state_q == FSM_IDLE);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      FSM_IDLE: begin
        if (in_valid_i) begin
          cmd_d       = command_i;
          mac_d       = mac_i;
          type_d      = node_type_i;
          kind_d      = query_kind_i;
          rd_idx_d    = '0;
          cv_d        = 1'b0;
          match_cnt_d = '0;
          held_v_d    = 1'b0;
          state_d     = FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        if (!stall) begin
          if (cmp_hit) begin
            if (held_v_q) begin
              out_valid_d = 1'b1;
              status_d    = STAT_ENTRY;
              out_id_d    = held_q.id;
              out_type_d  = held_q.node_type;
              out_mac_d   = held_q.mac;
              out_last_d  = 1'b0;
            end
            held_d      = rdata_q;
            held_v_d    = 1'b1;
            match_cnt_d = match_next;
          end
          if (issue) begin
            rd_en    = 1'b1;
            rd_idx_d = rd_idx_q + CntW'(1);
            cv_d     = 1'b1;
          end else begin
            cv_d = 1'b0;
          end
          if (!cv_q && !issue) begin
            state_d = FSM_DONE;
          end
        end
      end
      FSM_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          state_d     = FSM_IDLE;
          if (held_v_q) begin
            status_d   = (cmd_q == CMD_REQUEST) ? STAT_KNOWN : STAT_ENTRY;
            out_id_d   = held_q.id;
            out_type_d = held_q.node_type;
            out_mac_d  = held_q.mac;
          end else if (cmd_q == CMD_QUERY) begin
            status_d   = STAT_EMPTY;
            out_id_d   = '0;
            out_type_d = '0;
            out_mac_d  = '0;
          end else if (entry_count_q == CntW'(TABLE_DEPTH)) begin
            status_d   = STAT_FULL;
            out_id_d   = '0;
            out_type_d = type_q;
            out_mac_d  = mac_q;
          end else begin
            status_d      = STAT_NEW;
            out_id_d      = next_id_q;
            out_type_d    = type_q;
            out_mac_d     = mac_q;
            wr_en         = 1'b1;
            next_id_d     = next_id_q + ID_W'(1);
            entry_count_d = entry_count_q + CntW'(1);
          end
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FIRST_ID: begin
          // the counter follows first_id only while the table is empty
          if (entry_count_q == '0) begin
            next_id_d = cfg_data_i[ID_W-1:0];
          end
        end
        CFG_OPERATOR: op_type_d  = cfg_data_i[TYPE_W-1:0];
        CFG_VEHICLE:  veh_type_d = cfg_data_i[TYPE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= FSM_IDLE;
      entry_count_q <= '0;
      next_id_q     <= FIRST_ID_RST;
      op_type_q     <= OPERATOR_TYPE_RST;
      veh_type_q    <= VEHICLE_TYPE_RST;
      cv_q          <= 1'b0;
      held_v_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      entry_count_q <= entry_count_d;
      next_id_q     <= next_id_d;
      op_type_q     <= op_type_d;
      veh_type_q    <= veh_type_d;
      cv_q          <= cv_d;
      held_v_q      <= held_v_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    mac_q       <= mac_d;
    type_q      <= type_d;
    kind_q      <= kind_d;
    rd_idx_q    <= rd_idx_d;
    match_cnt_q <= match_cnt_d;
    held_q      <= held_d;
    status_q    <= status_d;
    out_id_q    <= out_id_d;
    out_type_q  <= out_type_d;
    out_mac_q   <= out_mac_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign subsystem_id_o = out_id_q;
  assign entry_type_o   = out_type_q;
  assign entry_mac_o    = out_mac_q;
  assign last_item_o    = out_last_q;

endmodule

`default_nettype wire

FILE: verif/tb_mac_keyed_id_allocator.sv
// testbench for mac_keyed_id_allocator: random and directed request/query traffic,
// replies predicted by an in-bench model of the node table and checked in order
// depends on mka_pkg and the mac_keyed_id_allocator rtl
`timescale 1ns / 1ps

module tb_mac_keyed_id_allocator;
  import mka_pkg::*;

  localparam int unsigned DEPTH       = TABLE_DEPTH_DEF;
  localparam logic [1:0]  CFG_SPARE   = 2'd3;  // unmapped register index, writes ignored
  localparam int          STALL_LIMIT = 4000;
  localparam int          SETTLE_CYC  = 2 * DEPTH + 8;

  typedef struct {
    logic              cmd;
    logic [MAC_W-1:0]  mac;
    logic [TYPE_W-1:0] ntype;
    qkind_e            kind;
  } node_cmd_t;

  typedef struct {
    status_e           status;
    logic [ID_W-1:0]   id;
    logic [TYPE_W-1:0] etype;
    logic [MAC_W-1:0]  mac;
    logic              last;
  } node_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic command_i = CMD_REQUEST;
  logic [MAC_W-1:0] mac_i = '0;
  logic [TYPE_W-1:0] node_type_i = '0;
  logic [1:0] query_kind_i = QK_ALL;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [2:0] status_o;
  logic [ID_W-1:0] subsystem_id_o;
  logic [TYPE_W-1:0] entry_type_o;
  logic [MAC_W-1:0] entry_mac_o;
  logic last_item_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = CFG_FIRST_ID;
  logic [CFG_W-1:0] cfg_data_i = '0;

  mac_keyed_id_allocator #(.TABLE_DEPTH(DEPTH)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .mac_i          (mac_i),
    .node_type_i    (node_type_i),
    .query_kind_i   (query_kind_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .subsystem_id_o (subsystem_id_o),
    .entry_type_o   (entry_type_o),
    .entry_mac_o    (entry_mac_o),
    .last_item_o    (last_item_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // node table model
  logic [MAC_W-1:0]  tbl_mac [DEPTH];
  logic [TYPE_W-1:0] tbl_type [DEPTH];
  logic [ID_W-1:0]   tbl_id [DEPTH];
  int unsigned       tbl_count = 0;
  logic [ID_W-1:0]   tbl_next_id = FIRST_ID_RST;
  logic [TYPE_W-1:0] cfg_operator = OPERATOR_TYPE_RST;
  logic [TYPE_W-1:0] cfg_vehicle = VEHICLE_TYPE_RST;

  node_cmd_t   cmd_q [$];
  node_reply_t reply_q [$];
  node_cmd_t   cur_cmd;
  logic [MAC_W-1:0] mac_pool [$];

  int n_pushed = 0;
  int n_cmds = 0;
  int n_replies = 0;
  int n_errors = 0;
  int stat_seen [5] = '{default: 0};
  int burst = 0;
  int max_burst = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch @%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    n_errors++;
  endtask

  function automatic void push_reply(input status_e st, input logic [ID_W-1:0] id,
                                     input logic [TYPE_W-1:0] ty,
                                     input logic [MAC_W-1:0] m, input logic last);
    node_reply_t r;
    r.status = st;
    r.id = id;
    r.etype = ty;
    r.mac = m;
    r.last = last;
    reply_q.push_back(r);
  endfunction

  function automatic void apply_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    case (idx)
      CFG_FIRST_ID: begin
        // counter only reloads while nothing is allocated
        if (tbl_count == 0) tbl_next_id = val;
      end
      CFG_OPERATOR: cfg_operator = val;
      CFG_VEHICLE:  cfg_vehicle = val;
      default: ;
    endcase
  endfunction

  function automatic void predict_replies(input node_cmd_t c);
    int i;
    int k;
    bit found;
    bit hit;
    int hits [$];
    found = 1'b0;
    if (c.cmd == CMD_REQUEST) begin
      for (i = 0; i < tbl_count; i++) begin
        if (!found && tbl_mac[i] == c.mac) begin
          found = 1'b1;
          push_reply(STAT_KNOWN, tbl_id[i], tbl_type[i], tbl_mac[i], 1'b1);
        end
      end
      if (!found) begin
        if (tbl_count >= DEPTH) begin
          push_reply(STAT_FULL, '0, c.ntype, c.mac, 1'b1);
        end else begin
          tbl_mac[tbl_count] = c.mac;
          tbl_type[tbl_count] = c.ntype;
          tbl_id[tbl_count] = tbl_next_id;
          push_reply(STAT_NEW, tbl_next_id, c.ntype, c.mac, 1'b1);
          tbl_next_id = tbl_next_id + 1'b1;
          tbl_count++;
        end
      end
    end else begin
      for (i = 0; i < tbl_count && hits.size() < RESULT_LIMIT; i++) begin
        case (c.kind)
          QK_ALL:      hit = 1'b1;
          QK_OPERATOR: hit = (tbl_type[i] == cfg_operator);
          QK_VEHICLE:  hit = (tbl_type[i] == cfg_vehicle);
          default:     hit = (tbl_mac[i] == c.mac);
        endcase
        if (hit) hits.push_back(i);
      end
      if (hits.size() == 0) begin
        push_reply(STAT_EMPTY, '0, '0, '0, 1'b1);
      end
      for (k = 0; k < hits.size(); k++) begin
        push_reply(STAT_ENTRY, tbl_id[hits[k]], tbl_type[hits[k]], tbl_mac[hits[k]],
                   k == hits.size() - 1);
      end
    end
  endfunction

  // driver: presents queued commands, holds each until accepted
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_replies(cur_cmd);
        n_cmds++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_cmd = cmd_q.pop_front();
          in_valid_i <= 1'b1;
          command_i <= cur_cmd.cmd;
          mac_i <= cur_cmd.mac;
          node_type_i <= cur_cmd.ntype;
          query_kind_i <= cur_cmd.kind;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_reply();
    node_reply_t want;
    n_replies++;
    if (status_o <= STAT_EMPTY) stat_seen[status_o]++;
    burst++;
    if (last_item_o === 1'b1) begin
      if (burst > max_burst) max_burst = burst;
      burst = 0;
    end
    if (reply_q.size() == 0) begin
      flag_mismatch("result with nothing pending, status", 64'(status_o), '0);
    end else begin
      want = reply_q.pop_front();
      if (status_o !== want.status)
        flag_mismatch("status", 64'(status_o), 64'(want.status));
      if (subsystem_id_o !== want.id)
        flag_mismatch("subsystem_id", 64'(subsystem_id_o), 64'(want.id));
      if (entry_type_o !== want.etype)
        flag_mismatch("entry_type", 64'(entry_type_o), 64'(want.etype));
      if (entry_mac_o !== want.mac)
        flag_mismatch("entry_mac", 64'(entry_mac_o), 64'(want.mac));
      if (last_item_o !== want.last)
        flag_mismatch("last_item", 64'(last_item_o), 64'(want.last));
    end
  endtask

  // monitor: random output backpressure, result checks and the stall watchdog
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) check_reply();
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) idle_cycles = 0;
      else idle_cycles++;
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[MAC_W-1:0];
  endfunction

  function automatic void push_cmd(input logic cmd, input logic [MAC_W-1:0] m,
                                   input logic [TYPE_W-1:0] ty, input qkind_e kind);
    node_cmd_t c;
    c.cmd = cmd;
    c.mac = m;
    c.ntype = ty;
    c.kind = kind;
    cmd_q.push_back(c);
    n_pushed++;
  endfunction

  // mostly requests that either hit a known node or bring a new one, plus queries
  function automatic void push_random_cmd();
    logic [MAC_W-1:0] m;
    logic [TYPE_W-1:0] ty;
    int sel;
    if ($urandom_range(99) < 55) begin
      if (mac_pool.size() != 0 && $urandom_range(99) < 40) begin
        m = mac_pool[$urandom_range(mac_pool.size() - 1)];
      end else begin
        m = rand_mac();
        mac_pool.push_back(m);
      end
      sel = $urandom_range(9);
      if (sel < 3) ty = cfg_operator;
      else if (sel < 6) ty = cfg_vehicle;
      else if (sel == 6) ty = '0;
      else if (sel == 7) ty = '1;
      else ty = TYPE_W'($urandom);
      push_cmd(CMD_REQUEST, m, ty, qkind_e'($urandom_range(3)));
    end else begin
      if (mac_pool.size() != 0 && $urandom_range(99) < 70)
        m = mac_pool[$urandom_range(mac_pool.size() - 1)];
      else
        m = rand_mac();
      push_cmd(CMD_QUERY, m, TYPE_W'($urandom), qkind_e'($urandom_range(3)));
    end
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (n_cmds != n_pushed || reply_q.size() != 0);
  endtask

  initial begin
    int p;
    int k;
    logic [CFG_W-1:0] fid;
    logic [CFG_W-1:0] op;
    logic [CFG_W-1:0] veh;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 12;
    recv_idle_pct = 61;
    // start just below the wrap so the id counter rolls over early
    write_reg(CFG_FIRST_ID, 16'hFFFE);

    push_cmd(CMD_QUERY, '0, TYPE_W'($urandom), QK_ALL);
    push_cmd(CMD_QUERY, '0, TYPE_W'($urandom), QK_MAC);
    push_cmd(CMD_REQUEST, '0, '0, QK_ALL);
    push_cmd(CMD_REQUEST, '1, '1, QK_MAC);
    push_cmd(CMD_REQUEST, '0, 16'h1234, QK_VEHICLE);   // known node keeps first type
    push_cmd(CMD_REQUEST, 48'h5555_5555_5555, OPERATOR_TYPE_RST, QK_ALL);
    push_cmd(CMD_REQUEST, 48'hAAAA_AAAA_AAAA, VEHICLE_TYPE_RST, QK_OPERATOR);
    push_cmd(CMD_QUERY, MAC_W'($urandom), TYPE_W'($urandom), QK_ALL);
    push_cmd(CMD_QUERY, MAC_W'($urandom), TYPE_W'($urandom), QK_OPERATOR);
    push_cmd(CMD_QUERY, MAC_W'($urandom), TYPE_W'($urandom), QK_VEHICLE);
    push_cmd(CMD_QUERY, '1, TYPE_W'($urandom), QK_MAC);
    push_cmd(CMD_QUERY, 48'h12_3456, TYPE_W'($urandom), QK_MAC);
    push_cmd(CMD_REQUEST, '1, '0, QK_ALL);
    mac_pool.push_back('0);
    mac_pool.push_back('1);
    mac_pool.push_back(48'h5555_5555_5555);
    mac_pool.push_back(48'hAAAA_AAAA_AAAA);
    wait_drained();

    for (p = 0; p < 6; p++) begin
      if (p < 2) begin
        send_idle_pct = 12;
        recv_idle_pct = 61;
      end else if (p < 4) begin
        send_idle_pct = 61;
        recv_idle_pct = 12;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      fid = CFG_W'($urandom);
      op = CFG_W'($urandom);
      veh = CFG_W'($urandom);
      case (p)
        0: begin
          fid = '0;
          op = '1;
          veh = '0;
        end
        1: fid = '1;
        2: begin
          op = '0;
          veh = '1;
        end
        3: veh = op;  // both filters select the same type
        4: begin
          op = OPERATOR_TYPE_RST;
          veh = VEHICLE_TYPE_RST;
        end
        default: ;
      endcase
      // table is populated here, so first_id must not reload the counter
      write_reg(CFG_FIRST_ID, fid);
      write_reg(CFG_OPERATOR, op);
      write_reg(CFG_VEHICLE, veh);
      write_reg(CFG_SPARE, CFG_W'($urandom));

      for (k = 0; k < 19; k++) push_random_cmd();
      // sender holds off until every pending result is back
      wait_drained();
      for (k = 0; k < 19; k++) push_random_cmd();
      wait_drained();
    end

    repeat (SETTLE_CYC) @(posedge clk_i);
    if (reply_q.size() != 0) flag_mismatch("results never seen", '0, 64'(reply_q.size()));

    $display("covered %0d commands, %0d results: %0d new, %0d known, %0d full,",
             n_cmds, n_replies, stat_seen[STAT_NEW], stat_seen[STAT_KNOWN],
             stat_seen[STAT_FULL]);
    $display("%0d entry, %0d empty; longest query report %0d results, table holds %0d nodes",
             stat_seen[STAT_ENTRY], stat_seen[STAT_EMPTY], max_burst, tbl_count);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
